// File: rtl/dlr_pkg.sv
// ----------------------------------------------------------------------------
// Dashed line rasterizer package
// Opcodes, register indexes and configuration widths and reset values.
// ----------------------------------------------------------------------------
package dlr_pkg;

	// Input word opcode
	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} opcode_t;

	// Configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_DASH_MASK  = 2'd0,
		REG_CLIP_MAX_X = 2'd1,
		REG_CLIP_MAX_Y = 2'd2,
		REG_UNUSED     = 2'd3
	} cfg_reg_t;

	// Configuration field widths
	localparam int DASH_BITS = 16;
	localparam int CLIP_BITS = 11;
	localparam int CFG_DATA_BITS = 16;

	// Reset values: solid line, square clip box
	localparam logic [DASH_BITS-1:0] DASH_MASK_RESET = 16'hFFFF;
	localparam logic [CLIP_BITS-1:0] CLIP_MAX_RESET  = 11'd792;

endpackage

// File: rtl/dashed_line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// Dashed line rasterizer
// Walks a line segment one pixel per step word with a residual rule, and
// flags each pixel against a dash mask and an inclusive clip box.
// ----------------------------------------------------------------------------
// Path: an input word passes through the input register, then the
//   single-pass walk update into the result register.
// Throughput: one word per cycle unless a stalled result blocks a step;
//   the walk update is one add-compare pass between the input and result registers.
// Reset: asynchronous, active low; walk goes idle, dash mask all ones,
//   clip limits 792. Configuration writes are always ready.
module dashed_line_rasterizer_top #(
	parameter int COORD_BITS = 12
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input channel
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  opcode,
	input  logic signed [COORD_BITS-1:0]          x_start,
	input  logic signed [COORD_BITS-1:0]          y_start,
	input  logic signed [COORD_BITS-1:0]          x_end,
	input  logic signed [COORD_BITS-1:0]          y_end,
	// Result channel
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [COORD_BITS-1:0]          pixel_x,
	output logic signed [COORD_BITS-1:0]          pixel_y,
	output logic                                  draw,
	output logic                                  last,
	// Configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dlr_pkg::CFG_IDX_BITS-1:0]      cfg_index,
	input  logic [dlr_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	localparam int RES_BITS = COORD_BITS + 2;
	localparam int SUM_BITS = (COORD_BITS + 1 > dlr_pkg::DASH_BITS) ?
		COORD_BITS + 1 : dlr_pkg::DASH_BITS;
	localparam int CMP_BITS = (COORD_BITS > dlr_pkg::CLIP_BITS) ?
		COORD_BITS : dlr_pkg::CLIP_BITS;

	// Configuration registers
	logic [dlr_pkg::DASH_BITS-1:0] dash_mask_q;
	logic [dlr_pkg::CLIP_BITS-1:0] clip_max_x_q;
	logic [dlr_pkg::CLIP_BITS-1:0] clip_max_y_q;

	// Input register
	logic                         valid_s1;
	dlr_pkg::opcode_t             opcode_s1;
	logic signed [COORD_BITS-1:0] x_start_s1, y_start_s1, x_end_s1, y_end_s1;

	// Walk state
	logic                         busy_q;
	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic [COORD_BITS-1:0]        delta_x_q, delta_y_q;
	logic                         neg_x_q, neg_y_q;
	logic                         major_is_x_q;
	logic [RES_BITS-1:0]          res_one_q, res_two_q;

	// Result register
	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
	logic                         draw_q, last_q;

	// Stage control
	logic out_free, is_load, is_step, produces, adv;
	logic at_end;

	// Load setup
	logic signed [COORD_BITS:0] dx_full, dy_full;
	logic [COORD_BITS:0]        dx_abs, dy_abs;
	logic [COORD_BITS-1:0]      load_dx, load_dy;

	// Step update
	logic                         res_gt;
	logic [RES_BITS-1:0]          d_major, d_minor;
	logic                         minor_move;
	logic signed [COORD_BITS-1:0] step_x, step_y;
	logic signed [COORD_BITS-1:0] emit_x, emit_y;

	// Pixel test
	logic signed [SUM_BITS-1:0]    ext_x, ext_y, dash_sum;
	logic                          dash_hit, in_box, draw_d;
	logic [CMP_BITS-1:0]           cmp_x, cmp_y, lim_x, lim_y;

	assign cfg_ready = 1'b1;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dash_mask_q  <= dlr_pkg::DASH_MASK_RESET;
			clip_max_x_q <= dlr_pkg::CLIP_MAX_RESET;
			clip_max_y_q <= dlr_pkg::CLIP_MAX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (dlr_pkg::cfg_reg_t'(cfg_index))
				dlr_pkg::REG_DASH_MASK:  dash_mask_q  <= cfg_data[dlr_pkg::DASH_BITS-1:0];
				dlr_pkg::REG_CLIP_MAX_X: clip_max_x_q <= cfg_data[dlr_pkg::CLIP_BITS-1:0];
				dlr_pkg::REG_CLIP_MAX_Y: clip_max_y_q <= cfg_data[dlr_pkg::CLIP_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Stage control: a word leaves the input register unless its pixel
	// has nowhere to go
	assign is_load  = (opcode_s1 == dlr_pkg::OP_LOAD);
	assign is_step  = (opcode_s1 == dlr_pkg::OP_STEP);
	assign produces = is_step && busy_q;
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && (!produces || out_free);
	assign in_stall = valid_s1 && !adv;

	// Input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Input register payload; hold while stalled
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			opcode_s1  <= dlr_pkg::opcode_t'(opcode);
			x_start_s1 <= x_start;
			y_start_s1 <= y_start;
			x_end_s1   <= x_end;
			y_end_s1   <= y_end;
		end
	end

	// Load setup: absolute deltas and step directions
	assign dx_full = {x_end_s1[COORD_BITS-1], x_end_s1} - {x_start_s1[COORD_BITS-1], x_start_s1};
	assign dy_full = {y_end_s1[COORD_BITS-1], y_end_s1} - {y_start_s1[COORD_BITS-1], y_start_s1};
	assign dx_abs  = dx_full[COORD_BITS] ? -dx_full : dx_full;
	assign dy_abs  = dy_full[COORD_BITS] ? -dy_full : dy_full;
	assign load_dx = dx_abs[COORD_BITS-1:0];
	assign load_dy = dy_abs[COORD_BITS-1:0];

	// Step update: residual compare, minor move, major move
	assign at_end     = major_is_x_q ? (cur_x_q == end_x_q) : (cur_y_q == end_y_q);
	assign d_major    = {2'b00, major_is_x_q ? delta_x_q : delta_y_q};
	assign d_minor    = {2'b00, major_is_x_q ? delta_y_q : delta_x_q};
	assign res_gt     = res_one_q > res_two_q;
	assign minor_move = res_gt;

	always_comb begin
		step_x = cur_x_q;
		step_y = cur_y_q;
		if (major_is_x_q || minor_move) begin
			step_x = neg_x_q ? cur_x_q - COORD_BITS'(1) : cur_x_q + COORD_BITS'(1);
		end
		if (!major_is_x_q || minor_move) begin
			step_y = neg_y_q ? cur_y_q - COORD_BITS'(1) : cur_y_q + COORD_BITS'(1);
		end
	end

	// Walk state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (adv) begin
			if (is_load) begin
				busy_q <= 1'b1;
			end else if (busy_q && at_end) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && is_load) begin
			cur_x_q      <= x_start_s1;
			cur_y_q      <= y_start_s1;
			end_x_q      <= x_end_s1;
			end_y_q      <= y_end_s1;
			delta_x_q    <= load_dx;
			delta_y_q    <= load_dy;
			neg_x_q      <= dx_full[COORD_BITS];
			neg_y_q      <= dy_full[COORD_BITS];
			major_is_x_q <= (load_dx >= load_dy);
			res_one_q    <= '0;
			res_two_q    <= '0;
		end else if (adv && produces && !at_end) begin
			cur_x_q   <= step_x;
			cur_y_q   <= step_y;
			res_one_q <= (res_gt ? '0 : res_one_q) + d_minor;
			if (res_gt) begin
				res_two_q <= res_two_q + d_major - res_one_q;
			end
		end
	end

	// Pixel test: dash mask on x plus or minus y, then the clip box
	assign emit_x   = at_end ? end_x_q : cur_x_q;
	assign emit_y   = at_end ? end_y_q : cur_y_q;
	assign ext_x    = SUM_BITS'(emit_x);
	assign ext_y    = SUM_BITS'(emit_y);
	assign dash_sum = (neg_x_q == neg_y_q) ? ext_x + ext_y : ext_x - ext_y;
	assign dash_hit = |(dash_sum[dlr_pkg::DASH_BITS-1:0] & dash_mask_q);
	assign cmp_x    = CMP_BITS'(unsigned'(emit_x));
	assign cmp_y    = CMP_BITS'(unsigned'(emit_y));
	assign lim_x    = CMP_BITS'(clip_max_x_q);
	assign lim_y    = CMP_BITS'(clip_max_y_q);
	assign in_box   = !emit_x[COORD_BITS-1] && !emit_y[COORD_BITS-1] &&
		(cmp_x <= lim_x) && (cmp_y <= lim_y);
	assign draw_d   = dash_hit && in_box;

	// Result register valid: load on a producing step, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && produces) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv && produces) begin
			pixel_x_q <= emit_x;
			pixel_y_q <= emit_y;
			draw_q    <= draw_d;
			last_q    <= at_end;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign draw      = draw_q;
	assign last      = last_q;

	// The endpoint word ends the walk
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && produces && at_end |=> !busy_q)
		else $error("walk still busy after endpoint word");

	// Stall only with a word held in the input register
	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && produces)
		else $error("input stalled without a pending pixel");

	// A new result only comes from a step of an active walk
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(busy_q) && $past(is_step))
		else $error("result word without an active walk");

	// A held result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |-> !(adv && produces))
		else $error("result word overwritten while stalled");

endmodule
